// ===== sv/laps_pkg.sv =====
// ----------------------------------------------------------------------------
// laps_pkg
// Widths, state word layout and register codes shared by the leaf area
// phenology step block and its channel interfaces
// ----------------------------------------------------------------------------
package laps_pkg;

  localparam int CELL_W  = 12;
  localparam int CLASS_W = 6;
  localparam int TEMP_W  = 11;
  localparam int RAIN_W  = 16;
  localparam int LAI_W   = 16;
  localparam int INIT_W  = 9;
  localparam int DAY_W   = 10;
  localparam int SUM_W   = 24;
  localparam int TTHR_W  = 10;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [DAY_W-1:0]   DAY_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX = '1;
  localparam logic [CLASS_W-1:0] EVERGREEN_LAST = CLASS_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROWTH_TEMP = 2'd0,
    CFG_RAIN_START  = 2'd1,
    CFG_ARID_RAIN   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DAY_W-1:0] day;
    logic             grown;
    logic [SUM_W-1:0] rsum;
  } laps_state_t;

  localparam int STATE_W = $bits(laps_state_t);

endpackage

// ===== sv/laps_in_if.sv =====
// ----------------------------------------------------------------------------
// laps_in_if
// Input channel: one daily item of one grid cell, valid/ready handshake
// ----------------------------------------------------------------------------
interface laps_in_if import laps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CELL_W-1:0]         cell_req;
  logic [CLASS_W-1:0]        land_class;
  logic                      arid_cell;
  logic signed [TEMP_W-1:0]  temperature;
  logic [RAIN_W-1:0]         rainfall;
  logic [LAI_W-1:0]          lai_floor;
  logic [LAI_W-1:0]          lai_ceiling;
  logic [INIT_W-1:0]         start_days;

  modport source (
    output valid, cell_req, land_class, arid_cell, temperature, rainfall,
           lai_floor, lai_ceiling, start_days,
    input  ready
  );
  modport sink (
    input  valid, cell_req, land_class, arid_cell, temperature, rainfall,
           lai_floor, lai_ceiling, start_days,
    output ready
  );
endinterface

// ===== sv/laps_out_if.sv =====
// ----------------------------------------------------------------------------
// laps_out_if
// Result channel: daily leaf area and grown flag, valid/ready handshake
// ----------------------------------------------------------------------------
interface laps_out_if import laps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LAI_W-1:0]  leaf_area;
  logic              fully_grown;

  modport source (output valid, leaf_area, fully_grown, input ready);
  modport sink (input valid, leaf_area, fully_grown, output ready);
endinterface

// ===== sv/laps_ram.sv =====
// ----------------------------------------------------------------------------
// laps_ram
// Simple dual-port synchronous RAM, one write and one registered read port
// ----------------------------------------------------------------------------
module laps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                  wdata,
  input  logic                              re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/leaf_area_phenology_step_top.sv =====
// ----------------------------------------------------------------------------
// leaf_area_phenology_step_top
// Daily leaf area per grid cell: per-cell day counter, grown flag and rain
// sum held in one state memory, read, updated and written back per item
//
//   channel   dir   handshake          payload
//   in_ch     in    valid / ready      cell, class, arid, temp, rain, lai range,
//                                      start days
//   out_ch    out   valid / ready      leaf_area, fully_grown
//   cfg_*     in    cfg_we             cfg_idx, cfg_wdata
//
// an item is accepted in idle, then passes cell index reduction (S_IDX1,
// S_IDX2), memory read, ramp scaling multiply, and write back and result
// after reset the state memory is swept to zero, one entry a cycle, and
// no item is taken before the sweep ends
// a held result stalls the write back; no new item is taken meanwhile
// ----------------------------------------------------------------------------
module leaf_area_phenology_step_top import laps_pkg::*; #(
  parameter int CELLS     = 4096,
  parameter int RAMP_DAYS = 30
) (
  input  logic                 clk,
  input  logic                 rst_n,
  laps_in_if.sink              in_ch,
  laps_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int KW  = $clog2(RAMP_DAYS + 1);
  // cell index reduction by reciprocal
  localparam int CS  = CELL_W + $clog2(CELLS + 1);
  localparam int CRW = CS + 1;
  localparam logic [CRW-1:0] CellRecip = CRW'(((65'd1 << CS) / CELLS) + 1);
  localparam int CPW = CELL_W + CRW;
  // ramp quotient by reciprocal
  localparam int RS  = LAI_W + 2 * KW;
  localparam int RRW = RS + 1;
  localparam logic [RRW-1:0] RampRecip = RRW'(((65'd1 << RS) / RAMP_DAYS) + 1);
  localparam int NW  = LAI_W + KW;
  localparam int RPW = NW + RRW;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_IDX1, S_IDX2, S_RD, S_MUL, S_FIN
  } state_t;

  state_t state_r;

  logic [AW-1:0]            clr_addr_r;
  logic signed [TTHR_W-1:0] temp_thr_r;
  logic [RAIN_W-1:0]        rain_thr_r;
  logic [RAIN_W-1:0]        arid_thr_r;

  logic [CELL_W-1:0]        cell_r;
  logic [CLASS_W-1:0]       class_r;
  logic                     arid_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [RAIN_W-1:0]        prec_r;
  logic [LAI_W-1:0]         lmin_r;
  logic [LAI_W-1:0]         lmax_r;
  logic [INIT_W-1:0]        init_r;

  logic [CELL_W-1:0]        cq_r;
  logic [AW-1:0]            addr_r;
  logic [DAY_W-1:0]         d_new_r;
  logic                     g_new_r;
  logic [SUM_W-1:0]         s_new_r;
  logic [LAI_W-1:0]         base_r;
  logic                     neg_r;
  logic [NW-1:0]            magn_r;
  logic [LAI_W-1:0]         qmag_r;

  logic                     out_valid_r;
  logic [LAI_W-1:0]         leaf_area_r;
  logic                     fully_grown_r;

  // memory port
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [STATE_W-1:0]       ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [STATE_W-1:0]       ram_rdata;

  // datapath
  logic                     in_acc;
  logic                     fin_go;
  logic [CPW-1:0]           cprod;
  logic [CELL_W-1:0]        cell_mod;
  logic [RPW-1:0]           rprod;
  laps_state_t              rd_st;
  logic                     warm;
  logic                     active;
  logic [DAY_W:0]           d11;
  logic [DAY_W:0]           init11;
  logic [DAY_W:0]           lim11;
  logic [DAY_W-1:0]         dinc;
  logic [SUM_W:0]           s25;
  logic [SUM_W-1:0]         sum_sat;
  logic [DAY_W-1:0]         d_n;
  logic                     g_n;
  logic [SUM_W-1:0]         s_n;
  logic [KW-1:0]            k_n;
  logic                     sub_n;
  logic signed [LAI_W:0]    diff;
  logic [LAI_W-1:0]         absdiff;
  logic [LAI_W-1:0]         lai_fin;

  assign in_ch.ready    = (state_r == S_IDLE);
  assign in_acc         = in_ch.valid && in_ch.ready;
  assign fin_go         = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.leaf_area   = leaf_area_r;
  assign out_ch.fully_grown = fully_grown_r;

  // cell modulo CELLS
  assign cprod    = CPW'(cell_r) * CPW'(CellRecip);
  assign cell_mod = cell_r - CELL_W'(cq_r * CELLS);

  assign ram_re    = (state_r == S_IDX2);
  assign ram_raddr = AW'(cell_mod);
  assign ram_we    = (state_r == S_CLEAR) || fin_go;
  assign ram_waddr = (state_r == S_CLEAR) ? clr_addr_r : addr_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : {d_new_r, g_new_r, s_new_r};

  laps_ram #(
    .WIDTH (STATE_W),
    .DEPTH (CELLS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // update rules on the read state
  always_comb begin
    rd_st   = laps_state_t'(ram_rdata);
    warm    = temp_r > TEMP_W'(temp_thr_r);
    d11     = {1'b0, rd_st.day};
    init11  = (DAY_W + 1)'(init_r);
    lim11   = init11 + (DAY_W + 1)'(RAMP_DAYS);
    dinc    = (rd_st.day == DAY_MAX) ? rd_st.day : rd_st.day + 1'b1;
    s25     = {1'b0, rd_st.rsum} + (SUM_W + 1)'(prec_r);
    sum_sat = s25[SUM_W] ? SUM_MAX : s25[SUM_W-1:0];
    active  = warm ? (d11 >= init11) : (d11 > init11);
    d_n     = rd_st.day;
    g_n     = rd_st.grown;
    s_n     = rd_st.rsum;
    k_n     = '0;
    sub_n   = 1'b0;
    if (!rd_st.grown) begin
      s_n = sum_sat;
      if (active) begin
        if (sum_sat > SUM_W'(rain_thr_r)) begin
          if ({1'b0, dinc} >= lim11) begin
            d_n = DAY_W'(lim11);
            g_n = 1'b1;
            k_n = KW'(RAMP_DAYS);
          end else begin
            d_n = dinc;
            k_n = KW'({1'b0, dinc} - init11);
          end
        end else begin
          d_n = DAY_W'(init11);
        end
      end else if (warm) begin
        d_n = dinc;
      end
    end else begin
      sub_n = 1'b1;
      if (d11 <= (DAY_W + 1)'(RAMP_DAYS)) begin
        if (rd_st.day <= DAY_W'(1)) begin
          d_n = '0;
          g_n = 1'b0;
          s_n = '0;
          k_n = KW'(RAMP_DAYS);
        end else begin
          d_n = rd_st.day - 1'b1;
          g_n = !(warm && (class_r <= EVERGREEN_LAST));
          k_n = KW'((DAY_W + 1)'(RAMP_DAYS) - d11 + 1'b1);
        end
      end else if (!warm || (arid_r && (prec_r < arid_thr_r))) begin
        d_n = rd_st.day - 1'b1;
      end else begin
        d_n = DAY_W'(lim11);
      end
    end
    diff    = $signed({1'b0, lmax_r}) - $signed({1'b0, lmin_r});
    absdiff = diff[LAI_W] ? LAI_W'(-diff) : LAI_W'(diff);
  end

  assign rprod   = RPW'(magn_r) * RPW'(RampRecip);
  assign lai_fin = neg_r ? (base_r - qmag_r) : (base_r + qmag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      temp_thr_r  <= TTHR_W'(80);
      rain_thr_r  <= RAIN_W'(4000);
      arid_thr_r  <= RAIN_W'(50);
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_GROWTH_TEMP: temp_thr_r <= cfg_wdata[TTHR_W-1:0];
          CFG_RAIN_START:  rain_thr_r <= cfg_wdata[RAIN_W-1:0];
          CFG_ARID_RAIN:   arid_thr_r <= cfg_wdata[RAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready && !fin_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            cell_r  <= in_ch.cell_req;
            class_r <= in_ch.land_class;
            arid_r  <= in_ch.arid_cell;
            temp_r  <= in_ch.temperature;
            prec_r  <= in_ch.rainfall;
            lmin_r  <= in_ch.lai_floor;
            lmax_r  <= in_ch.lai_ceiling;
            init_r  <= in_ch.start_days;
            state_r <= S_IDX1;
          end
        end
        S_IDX1: begin
          cq_r    <= cprod[CS+CELL_W-1:CS];
          state_r <= S_IDX2;
        end
        S_IDX2: begin
          addr_r  <= ram_raddr;
          state_r <= S_RD;
        end
        S_RD: begin
          d_new_r <= d_n;
          g_new_r <= g_n;
          s_new_r <= s_n;
          base_r  <= sub_n ? lmax_r : lmin_r;
          neg_r   <= sub_n ^ diff[LAI_W];
          magn_r  <= NW'(absdiff) * NW'(k_n);
          state_r <= S_MUL;
        end
        S_MUL: begin
          qmag_r  <= rprod[RS+LAI_W-1:RS];
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid_r   <= 1'b1;
            leaf_area_r   <= lai_fin;
            fully_grown_r <= g_new_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // an accepted item reaches write back after the index, read and multiply stages
  a_acc_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##5 (state_r == S_FIN))
    else $error("item did not reach write back in time");

  // a grown cell never stores a zero day count
  a_grown_day: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && g_new_r) |-> (d_new_r != '0))
    else $error("grown cell written with zero day count");

  // a new result only follows a write back
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside write back");

  // no item is taken during the clearing sweep
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> ((state_r == S_CLEAR) || (state_r == S_IDLE)))
    else $error("left clearing sweep into item processing");

endmodule
